// ===== rtl/qmm_pkg.sv =====
// Shared types and constants for the quad motor mixer.
package qmm_pkg;

    localparam int PULSE_W    = 12;
    localparam int IN_W       = 16;
    // throttle plus three torques of either sign needs three more bits
    localparam int MIX_W      = IN_W + 3;
    localparam int NUM_MOTORS = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = CFG_IDX_W'(1);

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = PULSE_W'(1000);
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = PULSE_W'(1990);

    typedef logic signed [MIX_W-1:0] mix_t;

    typedef struct packed {
        logic        [IN_W-1:0] throttle;
        logic signed [IN_W-1:0] torque_roll;
        logic signed [IN_W-1:0] torque_pitch;
        logic signed [IN_W-1:0] torque_yaw;
    } cmd_t;

    typedef struct packed {
        logic [PULSE_W-1:0] motor_one;
        logic [PULSE_W-1:0] motor_two;
        logic [PULSE_W-1:0] motor_three;
        logic [PULSE_W-1:0] motor_four;
        logic               scaled;
    } motor_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [PULSE_W-1:0]   wdata;
    } cfg_wr_t;

    // side data that rides along the divider pipeline
    typedef struct packed {
        logic                        scale;
        mix_t [NUM_MOTORS-1:0]       f;
    } mix_tag_t;

endpackage

// ===== rtl/qmm_chan_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
interface qmm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/qmm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
module qmm_div #(
    parameter int QW  = 32,
    parameter int DVW = 18,
    parameter int TW  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [QW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    input  logic [TW-1:0]  tag_in,
    output logic           out_valid,
    output logic [QW-1:0]  quotient,
    output logic [TW-1:0]  tag_out
);

    logic           vld_reg [QW];
    logic [DVW-1:0] rem_reg [QW];
    logic [QW-1:0]  num_reg [QW];
    logic [DVW-1:0] div_reg [QW];
    logic [TW-1:0]  tag_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic           vld_prev;
        logic [DVW-1:0] rem_prev;
        logic [QW-1:0]  num_prev;
        logic [DVW-1:0] div_prev;
        logic [TW-1:0]  tag_prev;
        logic [DVW:0]   part;
        logic           ge;
        logic [DVW-1:0] rem_next;
        logic [QW-1:0]  num_next;

        if (k == 0) begin : g_first
            assign vld_prev = in_valid;
            assign rem_prev = '0;
            assign num_prev = dividend;
            assign div_prev = divisor;
            assign tag_prev = tag_in;
        end else begin : g_rest
            assign vld_prev = vld_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
            assign div_prev = div_reg[k-1];
            assign tag_prev = tag_reg[k-1];
        end

        // num shifts dividend bits out at the top and quotient bits in at the bottom
        assign part     = {rem_prev, num_prev[QW-1]};
        assign ge       = part >= {1'b0, div_prev};
        assign rem_next = ge ? DVW'(part - {1'b0, div_prev}) : part[DVW-1:0];
        assign num_next = {num_prev[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_next;
                div_reg[k] <= div_prev;
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quotient  = num_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

    a_rem_first: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && (div_reg[0] != '0) |-> rem_reg[0] < div_reg[0])
        else $error("divider first stage remainder not below divisor");

    a_rem_mid: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW/2] && (div_reg[QW/2] != '0) |-> rem_reg[QW/2] < div_reg[QW/2])
        else $error("divider middle stage remainder not below divisor");

    a_rem_last: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW-1] && (div_reg[QW-1] != '0) |-> rem_reg[QW-1] < div_reg[QW-1])
        else $error("divider last stage remainder not below divisor");

endmodule

// ===== rtl/quad_motor_mixer_saturation_unit.sv =====
// Quad X-frame motor mixer with collective saturation scaling, top level.
//
//  channel  dir  payload                                     handshake
//  cmd      in   throttle, torque_roll/pitch/yaw             valid/ready
//  motors   out  motor_one..motor_four, scaled               valid/ready
//  cfg      in   index, wdata (0 min_pulse, 1 max_pulse)     valid/ready, ready tied high
//
//  One transaction per cycle in and out while the output is not stalled. The gamma quotient is QW = 12 +
//  FRACTION_BITS + GAMMA_FRACTION_BITS bits wide (32 at defaults), from the bit-per-stage divider.
//  Reset clears all valid bits and loads min_pulse 1000, max_pulse 1990.
//  Output register plus a skid entry: a result that meets a stalled output parks in the
//  skid entry, which freezes the whole pipeline and holds cmd.ready low until the output
//  takes a transaction; nothing dropped or repeated.
module quad_motor_mixer_saturation_unit #(
    parameter int FRACTION_BITS       = 4,
    parameter int GAMMA_FRACTION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    qmm_chan_if.sink   cmd,
    qmm_chan_if.source motors,
    qmm_chan_if.sink   cfg
);
    import qmm_pkg::*;

    localparam int QLIM_W = PULSE_W + FRACTION_BITS;
    localparam int CMP_W  = ((MIX_W > QLIM_W + 1) ? MIX_W : QLIM_W + 1) + 1;
    localparam int VIO_W  = CMP_W - 1;
    localparam int DVW    = MIX_W - 1;
    localparam int GW     = QLIM_W + GAMMA_FRACTION_BITS;
    localparam int GLO_W  = GW / 2;
    localparam int GHI_W  = GW - GLO_W;
    localparam int PLW    = MIX_W + GLO_W + 1;
    localparam int PHW    = MIX_W + GHI_W + 1;
    localparam int PW     = MIX_W + GW;
    localparam int SH     = FRACTION_BITS + GAMMA_FRACTION_BITS;
    localparam int WW     = PW - SH;
    localparam int TAG_W  = $bits(mix_tag_t);

    localparam logic [PW-1:0] HALF     = PW'(1) << (SH - 1);
    localparam logic [GW-1:0] GAMMA_ONE = GW'(1) << GAMMA_FRACTION_BITS;

    // ---------------- configuration ----------------
    logic [PULSE_W-1:0] min_reg;
    logic [PULSE_W-1:0] max_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_PULSE_RST;
            max_reg <= MAX_PULSE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_MIN_PULSE: min_reg <= cfg.data.wdata;
                REG_MAX_PULSE: max_reg <= cfg.data.wdata;
                default: ;
            endcase
        end
    end

    logic [QLIM_W-1:0]       lo_q;
    logic [QLIM_W-1:0]       hi_q;
    logic signed [CMP_W-1:0] lo_c;
    logic signed [CMP_W-1:0] hi_c;

    assign lo_q = QLIM_W'(min_reg) << FRACTION_BITS;
    assign hi_q = QLIM_W'(max_reg) << FRACTION_BITS;
    assign lo_c = $signed(CMP_W'(lo_q));
    assign hi_c = $signed(CMP_W'(hi_q));

    logic skid_vld_reg;
    logic en;
    assign en        = !skid_vld_reg;
    assign cmd.ready = en;

    // ---------------- stage A: mix ----------------
    mix_t t_x, r_x, p_x, y_x;
    mix_t a_f_next [NUM_MOTORS];
    mix_t a_f_reg  [NUM_MOTORS];
    logic a_vld_reg;

    assign t_x = MIX_W'(cmd.data.throttle);
    assign r_x = MIX_W'(cmd.data.torque_roll);
    assign p_x = MIX_W'(cmd.data.torque_pitch);
    assign y_x = MIX_W'(cmd.data.torque_yaw);

    assign a_f_next[0] = t_x - r_x - p_x - y_x;
    assign a_f_next[1] = t_x - r_x + p_x + y_x;
    assign a_f_next[2] = t_x + r_x + p_x - y_x;
    assign a_f_next[3] = t_x + r_x - p_x + y_x;

    // ---------------- stage B: violations ----------------
    logic [VIO_W-1:0] b_vio_next   [NUM_MOTORS];
    logic             b_above_next [NUM_MOTORS];
    logic [VIO_W-1:0] b_vio_reg    [NUM_MOTORS];
    logic             b_above_reg  [NUM_MOTORS];
    mix_t             b_f_reg      [NUM_MOTORS];
    logic             b_vld_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            b_above_next[i] = $signed(CMP_W'(a_f_reg[i])) > hi_c;
            if (b_above_next[i])
                b_vio_next[i] = VIO_W'($signed(CMP_W'(a_f_reg[i])) - hi_c);
            else if ($signed(CMP_W'(a_f_reg[i])) < lo_c)
                b_vio_next[i] = VIO_W'(lo_c - $signed(CMP_W'(a_f_reg[i])));
            else
                b_vio_next[i] = '0;
        end
    end

    // ---------------- stage C: worst channel ----------------
    // first index wins a tie: the later side is taken only when strictly larger
    logic             sel01, sel23, self;
    logic [VIO_W-1:0] v01, v23, worst;
    mix_t             f01, f23, fj;
    logic             ab01, ab23, abj;
    logic [QLIM_W-1:0] lim;
    mix_tag_t         c_tag_next;

    assign sel01 = b_vio_reg[1] > b_vio_reg[0];
    assign v01   = sel01 ? b_vio_reg[1] : b_vio_reg[0];
    assign f01   = sel01 ? b_f_reg[1] : b_f_reg[0];
    assign ab01  = sel01 ? b_above_reg[1] : b_above_reg[0];
    assign sel23 = b_vio_reg[3] > b_vio_reg[2];
    assign v23   = sel23 ? b_vio_reg[3] : b_vio_reg[2];
    assign f23   = sel23 ? b_f_reg[3] : b_f_reg[2];
    assign ab23  = sel23 ? b_above_reg[3] : b_above_reg[2];
    assign self  = v23 > v01;
    assign worst = self ? v23 : v01;
    assign fj    = self ? f23 : f01;
    assign abj   = self ? ab23 : ab01;
    assign lim   = abj ? hi_q : lo_q;

    always_comb
    begin
        c_tag_next.scale = (worst != '0) && ($signed(fj) > 0);
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            c_tag_next.f[i] = b_f_reg[i];
        end
    end

    mix_tag_t       c_tag_reg;
    logic [GW-1:0]  c_dividend_reg;
    logic [DVW-1:0] c_divisor_reg;
    logic           c_vld_reg;

    // ---------------- gamma divider ----------------
    logic           d_vld;
    logic [GW-1:0]  d_quot;
    mix_tag_t       d_tag;

    qmm_div #(
        .QW  (GW),
        .DVW (DVW),
        .TW  (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_vld_reg),
        .dividend  (c_dividend_reg),
        .divisor   (c_divisor_reg),
        .tag_in    (c_tag_reg),
        .out_valid (d_vld),
        .quotient  (d_quot),
        .tag_out   (d_tag)
    );

    // ---------------- stage M: partial products ----------------
    // unscaled items use gamma of exactly one, which reduces to plain rounding
    logic [GW-1:0]           gamma;
    logic signed [PLW-1:0]   glo_x;
    logic signed [PHW-1:0]   ghi_x;
    logic signed [PLW-1:0]   m_pl_next [NUM_MOTORS];
    logic signed [PHW-1:0]   m_ph_next [NUM_MOTORS];
    logic signed [PLW-1:0]   m_pl_reg  [NUM_MOTORS];
    logic signed [PHW-1:0]   m_ph_reg  [NUM_MOTORS];
    logic                    m_scale_reg;
    logic                    m_vld_reg;

    assign gamma = d_tag.scale ? d_quot : GAMMA_ONE;
    assign glo_x = PLW'(gamma[GLO_W-1:0]);
    assign ghi_x = PHW'(gamma[GW-1:GLO_W]);

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            m_pl_next[i] = PLW'($signed(d_tag.f[i])) * glo_x;
            m_ph_next[i] = PHW'($signed(d_tag.f[i])) * ghi_x;
        end
    end

    // ---------------- stage S1: product sum ----------------
    logic signed [PW-1:0] s1_v_next [NUM_MOTORS];
    logic signed [PW-1:0] s1_v_reg  [NUM_MOTORS];
    logic                 s1_scale_reg;
    logic                 s1_vld_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            s1_v_next[i] = PW'(m_pl_reg[i]) + (PW'(m_ph_reg[i]) <<< GLO_W);
        end
    end

    // ---------------- stage S2: round half away from zero ----------------
    logic signed [PW-1:0] rnd       [NUM_MOTORS];
    logic signed [WW-1:0] s2_w_next [NUM_MOTORS];
    logic signed [WW-1:0] s2_w_reg  [NUM_MOTORS];
    logic                 s2_scale_reg;
    logic                 s2_vld_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            // floor((v + half - neg) / 2^SH) equals rounding the magnitude
            rnd[i]       = s1_v_reg[i] + $signed(HALF - PW'(s1_v_reg[i][PW-1]));
            s2_w_next[i] = WW'(rnd[i] >>> SH);
        end
    end

    // ---------------- clamp into output ----------------
    logic [PULSE_W-1:0] mot [NUM_MOTORS];
    motor_t             res_next;

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            if (s2_w_reg[i] < $signed(WW'(min_reg)))
                mot[i] = min_reg;
            else if (s2_w_reg[i] > $signed(WW'(max_reg)))
                mot[i] = max_reg;
            else
                mot[i] = s2_w_reg[i][PULSE_W-1:0];
        end
        res_next.motor_one   = mot[0];
        res_next.motor_two   = mot[1];
        res_next.motor_three = mot[2];
        res_next.motor_four  = mot[3];
        res_next.scaled      = s2_scale_reg;
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg  <= cmd.valid;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            m_vld_reg  <= d_vld;
            s1_vld_reg <= m_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                a_f_reg[i]     <= a_f_next[i];
                b_f_reg[i]     <= a_f_reg[i];
                b_vio_reg[i]   <= b_vio_next[i];
                b_above_reg[i] <= b_above_next[i];
                m_pl_reg[i]    <= m_pl_next[i];
                m_ph_reg[i]    <= m_ph_next[i];
                s1_v_reg[i]    <= s1_v_next[i];
                s2_w_reg[i]    <= s2_w_next[i];
            end
            c_tag_reg      <= c_tag_next;
            c_dividend_reg <= GW'(lim) << GAMMA_FRACTION_BITS;
            c_divisor_reg  <= fj[DVW-1:0];
            m_scale_reg    <= d_tag.scale;
            s1_scale_reg   <= m_scale_reg;
            s2_scale_reg   <= s1_scale_reg;
        end
    end

    // ---------------- output register and skid entry ----------------
    logic   out_vld_reg;
    motor_t out_data_reg;
    motor_t skid_data_reg;
    logic   push;
    logic   out_fire;

    assign push     = s2_vld_reg && en;
    assign out_fire = out_vld_reg && motors.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_fire)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg || out_fire)
                out_vld_reg <= 1'b1;
            else
                skid_vld_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_vld_reg || out_fire)
                out_data_reg <= res_next;
            else
                skid_data_reg <= res_next;
        end
    end

    assign motors.valid = out_vld_reg;
    assign motors.data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held with output register empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !motors.ready && s2_vld_reg))
        else $error("skid entry filled without an output stall");

    a_scale_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && c_tag_reg.scale |-> c_divisor_reg != '0)
        else $error("scaling requested with zero divisor");

endmodule
